### src/wsd_pkg.sv
// Shared types, constants and helpers for the WebSocket frame deframer.
package wsd_pkg;

	localparam int LengthBitsDefault = 64;

	localparam logic [6:0] LenCode16 = 7'd126;
	localparam logic [6:0] LenCode64 = 7'd127;

	localparam logic [3:0] Ext16Bytes = 4'd2;
	localparam logic [3:0] Ext64Bytes = 4'd8;
	localparam logic [3:0] KeyBytes   = 4'd4;

	localparam logic [3:0] OpText   = 4'h1;
	localparam logic [3:0] OpBinary = 4'h2;
	localparam logic [3:0] OpClose  = 4'h8;

	localparam logic [1:0] KindOther  = 2'd0;
	localparam logic [1:0] KindText   = 2'd1;
	localparam logic [1:0] KindBinary = 2'd2;
	localparam logic [1:0] KindClose  = 2'd3;

	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXT16   = 6'b000100,
		PH_EXT64   = 6'b001000,
		PH_KEY     = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [1:0] frame_kind;
		logic       final_fragment;
		logic       last;
		logic       empty_frame;
	} result_t;

	function automatic logic [1:0] kind_of(input logic [3:0] op);
		logic [1:0] k;
		case (op)
			OpClose:  k = KindClose;
			OpText:   k = KindText;
			OpBinary: k = KindBinary;
			default:  k = KindOther;
		endcase
		return k;
	endfunction

endpackage

### src/wsd_parser.sv
// Header parser, length counter and unmasking for one byte per cycle while accept is high.
module wsd_parser #(
	parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        frame_byte,
	output logic              res_valid,
	output wsd_pkg::result_t  res
);

	wsd_pkg::phase_t          phase_q, phase_d;
	logic [3:0]               cnt_q, cnt_d;
	logic [LENGTH_BITS-1:0]   rem_q, rem_d;
	logic [31:0]              key_q, key_d;
	logic                     mp_q, mp_d;
	logic [1:0]               kidx_q, kidx_d;
	logic [3:0]               op_q, op_d;
	logic                     fin_q, fin_d;

	function automatic logic [3:0] Ext64Bytes_sel(input wsd_pkg::phase_t ph);
		return (ph == wsd_pkg::PH_EXT16) ? wsd_pkg::Ext16Bytes : wsd_pkg::Ext64Bytes;
	endfunction

	always_comb begin
		logic       len_done;
		logic       hdr_done;
		logic [3:0] need;
		logic [7:0] kbyte;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		key_d     = key_q;
		mp_d      = mp_q;
		kidx_d    = kidx_q;
		op_d      = op_q;
		fin_d     = fin_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		need      = Ext64Bytes_sel(phase_q);
		kbyte     = key_q[8*(3-kidx_q) +: 8];
		res_valid = 1'b0;
		res.payload_byte   = 8'd0;
		res.frame_kind     = wsd_pkg::kind_of(op_q);
		res.final_fragment = fin_q;
		res.last           = 1'b0;
		res.empty_frame    = 1'b0;

		case (phase_q)
			wsd_pkg::PH_SECOND: begin
				mp_d  = frame_byte[7];
				key_d = 32'd0;
				cnt_d = 4'd0;
				rem_d = '0;
				if (frame_byte[6:0] == wsd_pkg::LenCode16) begin
					phase_d = wsd_pkg::PH_EXT16;
				end else if (frame_byte[6:0] == wsd_pkg::LenCode64) begin
					phase_d = wsd_pkg::PH_EXT64;
				end else begin
					rem_d    = {{(LENGTH_BITS-7){1'b0}}, frame_byte[6:0]};
					len_done = 1'b1;
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				// saturate once the top byte is occupied
				if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0)
					rem_d = '1;
				else
					rem_d = {rem_q[LENGTH_BITS-9:0], frame_byte};
				cnt_d = cnt_q + 4'd1;
				if (cnt_d >= need)
					len_done = 1'b1;
			end
			wsd_pkg::PH_KEY: begin
				key_d = {key_q[23:0], frame_byte};
				cnt_d = cnt_q + 4'd1;
				if (cnt_d >= wsd_pkg::KeyBytes)
					hdr_done = 1'b1;
			end
			wsd_pkg::PH_PAYLOAD: begin
				res.payload_byte = mp_q ? (frame_byte ^ kbyte) : frame_byte;
				kidx_d = kidx_q + 2'd1;
				rem_d  = rem_q - LENGTH_BITS'(1);
				if (rem_d == '0) begin
					phase_d = wsd_pkg::PH_FIRST;
					kidx_d  = 2'd0;
				end
				res.last  = (rem_d == '0);
				res_valid = 1'b1;
			end
			default: begin
				fin_d   = frame_byte[7];
				op_d    = frame_byte[3:0];
				cnt_d   = 4'd0;
				kidx_d  = 2'd0;
				phase_d = wsd_pkg::PH_SECOND;
			end
		endcase

		if (len_done) begin
			cnt_d = 4'd0;
			if (mp_d)
				phase_d = wsd_pkg::PH_KEY;
			else
				hdr_done = 1'b1;
		end
		if (hdr_done) begin
			kidx_d = 2'd0;
			cnt_d  = 4'd0;
			if (rem_d == '0) begin
				phase_d         = wsd_pkg::PH_FIRST;
				res_valid       = 1'b1;
				res.last        = 1'b1;
				res.empty_frame = 1'b1;
			end else begin
				phase_d = wsd_pkg::PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_FIRST;
			cnt_q   <= 4'd0;
			rem_q   <= '0;
			key_q   <= 32'd0;
			mp_q    <= 1'b0;
			kidx_q  <= 2'd0;
			op_q    <= 4'd0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			key_q   <= key_d;
			mp_q    <= mp_d;
			kidx_q  <= kidx_d;
			op_q    <= op_d;
			fin_q   <= fin_d;
		end
	end

endmodule

### src/wsd_out_reg.sv
// Result register between the parser and the output channel.
module wsd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              load_valid,
	input  wsd_pkg::result_t  load_res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output wsd_pkg::result_t  out_res
);

	logic             valid_q;
	wsd_pkg::result_t res_q;

	// free when empty or being drained this cycle
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid)
			res_q <= load_res;
	end

endmodule

### src/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer.
// Takes one raw stream byte per item and deframes back-to-back RFC 6455
// frames: first header byte (FIN, opcode), second header byte (MASK, 7-bit
// length code), a 2- or 8-byte big-endian extended length for codes 126 and
// 127, then an optional 4-byte masking key. Each payload byte comes out
// unmasked with the frame kind (0 other, 1 text, 2 binary, 3 close), FIN,
// and last set on the final byte. A zero-length frame gives a single item
// with empty_frame and last set and payload_byte zero. Header and key bytes
// give no output item. Reserved bits and protocol violations are ignored.
// Lengths wider than LENGTH_BITS saturate to the all-ones value.
// Rate: one byte per clock, sustained. Each byte passes through the parser's
// state update and lands in a one-entry result register in the same cycle;
// in_ready stays high while that register is empty or being drained, so the
// only stall is a held-off output.
module websocket_frame_deframer_core #(
	parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] frame_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic [1:0] frame_kind,
	output logic       final_fragment,
	output logic       last,
	output logic       empty_frame
);

	logic             accept;
	logic             res_valid;
	logic             space;
	wsd_pkg::result_t res;
	wsd_pkg::result_t out_res;

	assign in_ready = space;
	assign accept   = in_valid && space;

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.frame_byte(frame_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_valid(res_valid),
		.load_res  (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign payload_byte   = out_res.payload_byte;
	assign frame_kind     = out_res.frame_kind;
	assign final_fragment = out_res.final_fragment;
	assign last           = out_res.last;
	assign empty_frame    = out_res.empty_frame;

endmodule

### bench/deframe_checker.sv
// Channel monitor for the deframer: predicts every output item and compares it.
module deframe_checker #(
	parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] frame_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] payload_byte,
	input  logic [1:0] frame_kind,
	input  logic       final_fragment,
	input  logic       last,
	input  logic       empty_frame,
	output int         mismatches,
	output int         outstanding
);

	localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LENGTH_BITS);

	wsd_pkg::phase_t  phase;
	logic [3:0]       hdr_count;
	logic [63:0]      remaining;
	logic [31:0]      key;
	logic             masked;
	logic [1:0]       key_idx;
	logic [3:0]       opcode;
	logic             fin;
	int               fail_total = 0;
	wsd_pkg::result_t due_outputs[$];

	task automatic push_output(input logic [7:0] data, input logic is_last,
			input logic is_empty);
		wsd_pkg::result_t r;
		r.payload_byte = data;
		case (opcode)
			wsd_pkg::OpClose:  r.frame_kind = wsd_pkg::KindClose;
			wsd_pkg::OpText:   r.frame_kind = wsd_pkg::KindText;
			wsd_pkg::OpBinary: r.frame_kind = wsd_pkg::KindBinary;
			default:           r.frame_kind = wsd_pkg::KindOther;
		endcase
		r.final_fragment = fin;
		r.last           = is_last;
		r.empty_frame    = is_empty;
		due_outputs = {due_outputs, r};
	endtask

	// header and key complete: payload follows, or the frame is empty
	task automatic end_of_header();
		key_idx   = '0;
		hdr_count = '0;
		if (remaining == 0) begin
			phase = wsd_pkg::PH_FIRST;
			push_output(8'h00, 1'b1, 1'b1);
		end else begin
			phase = wsd_pkg::PH_PAYLOAD;
		end
	endtask

	task automatic end_of_length();
		hdr_count = '0;
		if (masked)
			phase = wsd_pkg::PH_KEY;
		else
			end_of_header();
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] data;
		logic [3:0] need;
		need = (phase == wsd_pkg::PH_EXT16) ? wsd_pkg::Ext16Bytes : wsd_pkg::Ext64Bytes;
		case (phase)
			wsd_pkg::PH_SECOND: begin
				masked    = b[7];
				key       = '0;
				hdr_count = '0;
				remaining = '0;
				if (b[6:0] == wsd_pkg::LenCode16) begin
					phase = wsd_pkg::PH_EXT16;
				end else if (b[6:0] == wsd_pkg::LenCode64) begin
					phase = wsd_pkg::PH_EXT64;
				end else begin
					remaining = 64'(b[6:0]);
					end_of_length();
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				// saturate once the next shift would overflow
				if (remaining > (LenMax >> 8))
					remaining = LenMax;
				else
					remaining = ((remaining << 8) | 64'(b)) & LenMax;
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= need)
					end_of_length();
			end
			wsd_pkg::PH_KEY: begin
				key       = {key[23:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= wsd_pkg::KeyBytes)
					end_of_header();
			end
			wsd_pkg::PH_PAYLOAD: begin
				data = masked ? (b ^ key[8 * (3 - key_idx) +: 8]) : b;
				key_idx   = key_idx + 2'd1;
				remaining = (remaining - 64'd1) & LenMax;
				if (remaining == 0) begin
					phase   = wsd_pkg::PH_FIRST;
					key_idx = '0;
				end
				push_output(data, remaining == 0, 1'b0);
			end
			default: begin
				fin       = b[7];
				opcode    = b[3:0];
				hdr_count = '0;
				key_idx   = '0;
				phase     = wsd_pkg::PH_SECOND;
			end
		endcase
	endtask

	always @(posedge clk) begin
		wsd_pkg::result_t got;
		wsd_pkg::result_t want;
		if (!arst_n) begin
			phase     = wsd_pkg::PH_FIRST;
			hdr_count = '0;
			remaining = '0;
			key       = '0;
			masked    = 1'b0;
			key_idx   = '0;
			opcode    = '0;
			fin       = 1'b0;
			due_outputs.delete();
		end else begin
			// output first: an item leaving now came from an earlier byte
			if (out_valid && out_ready) begin
				got.payload_byte   = payload_byte;
				got.frame_kind     = frame_kind;
				got.final_fragment = final_fragment;
				got.last           = last;
				got.empty_frame    = empty_frame;
				if (due_outputs.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected item: byte %02h kind %0d fin %0b last %0b empty %0b",
							got.payload_byte, got.frame_kind, got.final_fragment,
							got.last, got.empty_frame);
				end else begin
					want = due_outputs.pop_front();
					if (got !== want) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"mismatch: expected byte %02h kind %0d fin %0b last %0b",
								" empty %0b, got byte %02h kind %0d fin %0b last %0b empty %0b"},
								want.payload_byte, want.frame_kind, want.final_fragment,
								want.last, want.empty_frame, got.payload_byte,
								got.frame_kind, got.final_fragment, got.last,
								got.empty_frame);
					end
				end
			end
			if (in_valid && in_ready)
				deframe_byte(frame_byte);
		end
		mismatches  <= fail_total;
		outstanding <= due_outputs.size();
	end

endmodule

### bench/testbench.sv
// Top of the deframer bench: clock, reset, frame stream stimulus and verdict.
module testbench;

	localparam int RandomBytes = 900;   // random part, counted in stream bytes
	localparam int CalmTail    = 120;   // final stretch runs with no idling
	localparam int Limit       = 400000;

	// length encodings for the stimulus
	localparam int Form7  = 0;
	localparam int Form16 = 1;
	localparam int Form64 = 2;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] frame_byte = 8'h00;
	logic       out_ready  = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] payload_byte;
	logic [1:0] frame_kind;
	logic       final_fragment;
	logic       last;
	logic       empty_frame;

	int fails;
	int waiting;
	int bytes_sent = 0;
	int cycles     = 0;
	bit quiet      = 1'b0;   // no idling on either side
	bit calm       = 1'b0;   // no sender gaps for the current frame

	initial begin
		forever #5 clk = ~clk;
	end

	websocket_frame_deframer_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_byte     (frame_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_byte   (payload_byte),
		.frame_kind     (frame_kind),
		.final_fragment (final_fragment),
		.last           (last),
		.empty_frame    (empty_frame)
	);

	deframe_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_byte     (frame_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_byte   (payload_byte),
		.frame_kind     (frame_kind),
		.final_fragment (final_fragment),
		.last           (last),
		.empty_frame    (empty_frame),
		.mismatches     (fails),
		.outstanding    (waiting)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == Limit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: ready in random runs, stalled in random bursts.
	// Once the tail starts it stays ready.
	initial begin
		do @(posedge clk); while (!arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// One stream byte per item. An optional gap comes before the item, so valid
	// is only dropped when a gap follows; back-to-back items keep valid high.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Whole frame: header, extended length in the chosen form, key if masked,
	// then random payload bytes.
	task automatic send_frame(input logic fin, input logic [2:0] rsv,
			input logic [3:0] op, input logic masked, input logic [63:0] len,
			input int form);
		logic [31:0] key;
		logic [6:0]  code;
		key  = $urandom;
		code = (form == Form16) ? wsd_pkg::LenCode16 :
			(form == Form64) ? wsd_pkg::LenCode64 : len[6:0];
		send_byte({fin, rsv, op});
		send_byte({masked, code});
		if (form == Form16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == Form64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		for (longint n = 0; n < len; n++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		logic [3:0]  op;
		logic [2:0]  rsv;
		logic [63:0] len;
		int          form;
		int          pick;
		case ($urandom_range(0, 7))
			0, 1:    op = wsd_pkg::OpText;
			2, 3:    op = wsd_pkg::OpBinary;
			4:       op = wsd_pkg::OpClose;
			default: op = 4'($urandom_range(0, 15));   // continuation, control, reserved
		endcase
		// reserved bits are ignored by the block but still driven
		rsv  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			form = Form7;
			len  = 64'($urandom_range(0, 12));
		end else if (pick < 58) begin
			form = Form7;
			len  = 64'($urandom_range(13, 125));
		end else if (pick < 80) begin
			form = Form16;
			len  = 64'($urandom_range(0, 48));
		end else if (pick < 83) begin
			// high length byte nonzero
			form = Form16;
			len  = 64'($urandom_range(256, 300));
		end else begin
			form = Form64;
			len  = 64'($urandom_range(0, 40));
		end
		send_frame(1'($urandom_range(0, 1)), rsv, op, $urandom_range(0, 3) != 0, len, form);
	endtask

	initial begin
		int start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames
		calm = 1'b1;
		send_frame(1'b1, 3'b000, wsd_pkg::OpText,   1'b0, 64'd0, Form7);   // empty text
		send_frame(1'b0, 3'b000, wsd_pkg::OpBinary, 1'b1, 64'd1, Form7);   // masked, one byte
		send_frame(1'b1, 3'b111, wsd_pkg::OpClose,  1'b0, 64'd0, Form16);  // zero 16-bit length
		send_frame(1'b0, 3'b000, 4'h0,              1'b0, 64'd0, Form64);  // zero 64-bit length
		send_frame(1'b1, 3'b000, 4'hf,              1'b0, 64'd1, Form7);   // reserved opcode

		// Random frames, quiet tail at the end
		start = bytes_sent;
		while (bytes_sent - start < RandomBytes) begin
			quiet = (bytes_sent - start) >= RandomBytes - CalmTail;
			calm  = $urandom_range(0, 3) == 0;
			send_random_frame();
		end
		quiet = 1'b1;
		in_valid <= 1'b0;

		// drain: outstanding count is registered, so step once before polling
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (fails == 0 && waiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
